// ===== hdl/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, codes and constants of the station temperature aggregator.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam logic [63:0] HASH_MUL_W = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_MUL_L = 64'hC2B2AE3D27D4EB4F;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFFFFFF;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_NAME       = 3'd0,
        PH_AFTER_SEMI = 3'd1,
        PH_AFTER_SIGN = 3'd2,
        PH_ONE_INT    = 3'd3,
        PH_TWO_INT    = 3'd4,
        PH_AFTER_DOT  = 3'd5,
        PH_AFTER_FRAC = 3'd6,
        PH_SKIP       = 3'd7
    } phase_t;

    // line summary handed from the parser to the table engine
    typedef struct packed {
        logic          too_long;
        logic          well_formed;
        logic [63:0]   prefix;
        logic signed [10:0] temp;
    } line_info_t;

endpackage

// ===== hdl/sta_ram.sv =====
// ----------------------------------------------------------------------------
// sta_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sta_parser.sv =====
// ----------------------------------------------------------------------------
// sta_parser
// Byte-level line parser: name capture, prefix word and temperature digits.
// ----------------------------------------------------------------------------
module sta_parser #(
    parameter int MAX_NAME_BYTES = 100,
    parameter int LW             = 7
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_en,
    input  logic [7:0]             text_byte,
    input  logic                   line_clear,
    output logic                   name_we,
    output logic [LW-1:0]          name_waddr,
    output logic [LW-1:0]          name_len,
    output sta_pkg::line_info_t    info
);

    sta_pkg::phase_t phase_reg, phase_next;
    logic [LW:0]   len_reg, len_next;
    logic [63:0]   prefix_reg, prefix_next;
    logic          neg_reg, neg_next;
    logic [9:0]    acc_reg, acc_next;
    logic          digit;
    logic [3:0]    dval;
    logic [9:0]    acc_x10;

    assign digit   = (text_byte >= sta_pkg::CH_ZERO) && (text_byte <= sta_pkg::CH_NINE);
    assign dval    = text_byte[3:0];
    assign acc_x10 = {acc_reg[6:0], 3'b000} + {acc_reg[8:0], 1'b0} + {6'd0, dval};

    always_comb begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        name_we     = 1'b0;
        if (line_clear) begin
            phase_next  = sta_pkg::PH_NAME;
            len_next    = '0;
            prefix_next = '0;
            neg_next    = 1'b0;
            acc_next    = '0;
        end else if (byte_en) begin
            case (phase_reg)
                sta_pkg::PH_NAME: begin
                    if (text_byte == sta_pkg::CH_SEMI) begin
                        phase_next = sta_pkg::PH_AFTER_SEMI;
                    end else if (len_reg < (LW+1)'(MAX_NAME_BYTES)) begin
                        name_we = 1'b1;
                        if (len_reg < (LW+1)'(8)) begin
                            prefix_next = prefix_reg | ({56'd0, text_byte} << {len_reg[2:0], 3'b000});
                        end
                        len_next = len_reg + 1'b1;
                    end else begin
                        len_next = (LW+1)'(MAX_NAME_BYTES + 1);
                    end
                end
                sta_pkg::PH_AFTER_SEMI: begin
                    if (text_byte == sta_pkg::CH_MINUS) begin
                        neg_next = 1'b1; phase_next = sta_pkg::PH_AFTER_SIGN;
                    end else if (digit) begin
                        acc_next = {6'd0, dval}; phase_next = sta_pkg::PH_ONE_INT;
                    end else begin
                        phase_next = sta_pkg::PH_SKIP;
                    end
                end
                sta_pkg::PH_AFTER_SIGN: begin
                    if (digit) begin
                        acc_next = {6'd0, dval}; phase_next = sta_pkg::PH_ONE_INT;
                    end else begin
                        phase_next = sta_pkg::PH_SKIP;
                    end
                end
                sta_pkg::PH_ONE_INT: begin
                    if (digit) begin
                        acc_next = acc_x10; phase_next = sta_pkg::PH_TWO_INT;
                    end else if (text_byte == sta_pkg::CH_DOT) begin
                        phase_next = sta_pkg::PH_AFTER_DOT;
                    end else begin
                        phase_next = sta_pkg::PH_SKIP;
                    end
                end
                sta_pkg::PH_TWO_INT: begin
                    phase_next = (text_byte == sta_pkg::CH_DOT) ? sta_pkg::PH_AFTER_DOT
                                                                : sta_pkg::PH_SKIP;
                end
                sta_pkg::PH_AFTER_DOT: begin
                    if (digit) begin
                        acc_next = acc_x10; phase_next = sta_pkg::PH_AFTER_FRAC;
                    end else begin
                        phase_next = sta_pkg::PH_SKIP;
                    end
                end
                default: phase_next = sta_pkg::PH_SKIP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sta_pkg::PH_NAME;
            len_reg    <= '0;
            prefix_reg <= '0;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
        end
    end

    assign name_waddr       = len_reg[LW-1:0];
    assign info.too_long    = len_reg > (LW+1)'(MAX_NAME_BYTES);
    assign name_len         = info.too_long ? LW'(MAX_NAME_BYTES) : len_reg[LW-1:0];
    assign info.well_formed = (phase_reg == sta_pkg::PH_AFTER_FRAC);
    assign info.prefix      = prefix_reg;
    assign info.temp        = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

// ===== hdl/sta_mul.sv =====
// ----------------------------------------------------------------------------
// sta_mul
// Shared 64x64 low-half multiplier, 16x64 partial product per cycle.
// ----------------------------------------------------------------------------
module sta_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod
);

    logic [63:0] a_reg, b_reg, acc_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] part;

    // one 16-bit digit of a each step, b shifted along
    assign part = {48'd0, a_reg[15:0]} * b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
            end else if (busy_reg) begin
                acc_reg <= acc_reg + part;
                a_reg   <= {16'd0, a_reg[63:16]};
                b_reg   <= {b_reg[47:0], 16'd0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 3'd3) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign prod = acc_reg;

endmodule

// ===== hdl/station_temperature_aggregator.sv =====
// ----------------------------------------------------------------------------
// station_temperature_aggregator
// Group-by of station temperature lines into an open-addressing table.
// ----------------------------------------------------------------------------
// A plain text byte goes straight into the parser. A newline byte hashes the
// name's first eight bytes and its length through one shared 64-bit multiplier
// (two products), then walks the table one slot at a time through S_PROBE,
// S_PWAIT and S_CHECK. A key match compares the name byte by byte in S_CMPRD
// and S_CMP, then updates in S_UPDATE. An insert copies the name bytes in
// S_COPY. A readout passes S_RDWAIT and S_RDOUT. After reset a clearing pass
// over all TABLE_SLOTS slots empties the key memory before the first word is
// taken. Results sit in an output register, and s_tready stays low while an
// item is in work or its result is still waiting.
module station_temperature_aggregator #(
    parameter int TABLE_SLOTS    = 1024,
    parameter int MAX_NAME_BYTES = 100
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // text_byte[7:0], read_slot[17:8], read_byte_index[24:18]
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // slot, occupied, inserted, status, name_len, name_byte,
                                    // temp, min, max, sum, sample_count
    output logic         m_tuser    // is_readout
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int LW = 7;
    localparam int NW = $clog2(MAX_NAME_BYTES);
    localparam int BW = $clog2(TABLE_SLOTS * MAX_NAME_BYTES);
    localparam int DW = 1 + LW + 64;
    localparam int AW = 11 + 11 + 43 + 32;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_HASH1  = 14'b00000000000100,
        S_HASH2  = 14'b00000000001000,
        S_PROBE  = 14'b00000000010000,
        S_PWAIT  = 14'b00000000100000,
        S_CHECK  = 14'b00000001000000,
        S_CMPRD  = 14'b00000010000000,
        S_CMP    = 14'b00000100000000,
        S_UPDATE = 14'b00001000000000,
        S_COPY   = 14'b00010000000000,
        S_RDWAIT = 14'b00100000000000,
        S_RDOUT  = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic       op;
    logic [7:0] text_byte;
    logic [9:0] read_slot;
    logic [6:0] read_byte_index;
    assign op              = s_tuser;
    assign text_byte       = s_tdata[7:0];
    assign read_slot       = s_tdata[17:8];
    assign read_byte_index = s_tdata[24:18];

    logic accept;
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;

    // parser
    logic                name_we, line_clear;
    logic [LW-1:0]       name_waddr, name_len;
    sta_pkg::line_info_t info;
    sta_parser #(.MAX_NAME_BYTES(MAX_NAME_BYTES), .LW(LW)) u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .byte_en(accept && !op && text_byte != sta_pkg::CH_NL),
        .text_byte(text_byte), .line_clear(line_clear),
        .name_we(name_we), .name_waddr(name_waddr), .name_len(name_len), .info(info)
    );

    // shared multiplier
    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;
    sta_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_p)
    );

    // control registers
    logic [63:0]   h_reg, h_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW:0]   tries_reg, tries_next;
    logic [LW-1:0] bi_reg, bi_next;
    logic [6:0]    rd_bi_reg, rd_bi_next;
    logic [SW:0]   clr_reg, clr_next;

    // line name buffer
    logic [LW-1:0] nb_raddr;
    logic [7:0]    nb_rdata;
    sta_ram #(.WIDTH(8), .DEPTH(MAX_NAME_BYTES)) u_namebuf (
        .aclk(aclk), .we(name_we), .waddr(name_waddr[NW-1:0]), .wdata(text_byte),
        .raddr(nb_raddr[NW-1:0]), .rdata(nb_rdata)
    );

    // slot key memory: {used, len, key}
    logic          dir_we;
    logic [SW-1:0] dir_waddr, dir_raddr;
    logic [DW-1:0] dir_wdata, dir_rdata;
    sta_ram #(.WIDTH(DW), .DEPTH(TABLE_SLOTS)) u_dir (
        .aclk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .raddr(dir_raddr), .rdata(dir_rdata)
    );

    // aggregates: {min, max, sum, count}
    logic          agg_we;
    logic [AW-1:0] agg_wdata, agg_rdata;
    sta_ram #(.WIDTH(AW), .DEPTH(TABLE_SLOTS)) u_agg (
        .aclk(aclk), .we(agg_we), .waddr(idx_reg), .wdata(agg_wdata),
        .raddr(dir_raddr), .rdata(agg_rdata)
    );

    // slot name bytes
    logic          sn_we;
    logic [BW-1:0] sn_waddr, sn_raddr;
    logic [7:0]    sn_rdata;
    sta_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * MAX_NAME_BYTES)) u_names (
        .aclk(aclk), .we(sn_we), .waddr(sn_waddr), .wdata(nb_rdata),
        .raddr(sn_raddr), .rdata(sn_rdata)
    );

    logic [BW-1:0] slot_base;
    assign slot_base = BW'(idx_reg) * BW'(MAX_NAME_BYTES);

    // aggregate update arithmetic
    logic signed [10:0] a_min, a_max, n_min, n_max;
    logic signed [42:0] a_sum;
    logic [31:0]        a_cnt;
    assign {a_min, a_max, a_sum, a_cnt} = agg_rdata;
    assign n_min = (info.temp < a_min) ? info.temp : a_min;
    assign n_max = (info.temp > a_max) ? info.temp : a_max;

    logic       key_hit;
    assign key_hit = dir_rdata[DW-1] && dir_rdata[63:0] == h_reg
                     && dir_rdata[DW-2 -: LW] == name_len;

    // output register
    logic         o_valid_reg, o_valid_next;
    logic [143:0] o_data_reg, o_data_next;
    logic         o_user_reg, o_user_next;

    // agg comes in as {min, max, sum, count}; the word wants min lowest
    function automatic logic [143:0] pack_out(
        input logic [9:0] slot, input logic occ, input logic ins, input logic [2:0] st,
        input logic [6:0] nl, input logic [7:0] nbyte, input logic [10:0] t,
        input logic [AW-1:0] agg);
        pack_out = {6'd0, agg[31:0], agg[74:32], agg[85:75], agg[96:86],
                    t, nbyte, nl, st, ins, occ, slot};
    endfunction

    always_comb begin
        state_next   = state_reg;
        h_next       = h_reg;
        idx_next     = idx_reg;
        tries_next   = tries_reg;
        bi_next      = bi_reg;
        rd_bi_next   = rd_bi_reg;
        clr_next     = clr_reg;
        o_valid_next = o_valid_reg && !m_tready;
        o_data_next  = o_data_reg;
        o_user_next  = o_user_reg;
        mul_start    = 1'b0;
        mul_a        = info.prefix;
        mul_b        = sta_pkg::HASH_MUL_W;
        line_clear   = 1'b0;
        dir_we       = 1'b0;
        dir_waddr    = idx_reg;
        dir_wdata    = {1'b1, name_len, h_reg};
        dir_raddr    = idx_reg;
        agg_we       = 1'b0;
        agg_wdata    = '0;
        sn_we        = 1'b0;
        sn_waddr     = slot_base + BW'(bi_reg);
        sn_raddr     = slot_base + BW'(bi_reg);
        nb_raddr     = bi_reg;
        case (state_reg)
            S_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = clr_reg[SW-1:0];
                dir_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (SW+1)'(TABLE_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && op) begin
                    idx_next   = read_slot[SW-1:0];
                    rd_bi_next = read_byte_index;
                    state_next = S_RDWAIT;
                end else if (accept && text_byte == sta_pkg::CH_NL) begin
                    if (info.too_long) begin
                        o_valid_next = 1'b1; o_user_next = 1'b0;
                        o_data_next  = pack_out('0, 1'b0, 1'b0, sta_pkg::ST_TOO_LONG,
                                                name_len, '0, '0, '0);
                        line_clear = 1'b1;
                    end else if (!info.well_formed) begin
                        o_valid_next = 1'b1; o_user_next = 1'b0;
                        o_data_next  = pack_out('0, 1'b0, 1'b0, sta_pkg::ST_MALFORMED,
                                                name_len, '0, '0, '0);
                        line_clear = 1'b1;
                    end else begin
                        mul_start  = 1'b1;
                        state_next = S_HASH1;
                    end
                end
            end
            S_HASH1: begin
                if (mul_done) begin
                    h_next     = mul_p;
                    mul_start  = 1'b1;
                    mul_a      = {57'd0, name_len};
                    mul_b      = sta_pkg::HASH_MUL_L;
                    state_next = S_HASH2;
                end
            end
            S_HASH2: begin
                if (mul_done) begin
                    h_next     = ((h_reg ^ mul_p) == 64'd0) ? 64'd1 : (h_reg ^ mul_p);
                    idx_next   = ((h_reg ^ mul_p) == 64'd0) ? SW'(1) : SW'(h_reg ^ mul_p);
                    tries_next = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                bi_next = '0;
                if (!dir_rdata[DW-1]) begin
                    dir_we     = 1'b1;
                    agg_we     = 1'b1;
                    agg_wdata  = {info.temp, info.temp, 43'(info.temp), 32'd1};
                    state_next = S_COPY;
                end else if (key_hit) begin
                    state_next = S_CMPRD;
                end else if (tries_reg == (SW+1)'(TABLE_SLOTS - 1)) begin
                    o_valid_next = 1'b1; o_user_next = 1'b0;
                    o_data_next  = pack_out('0, 1'b0, 1'b0, sta_pkg::ST_FULL,
                                            name_len, '0, info.temp, '0);
                    line_clear = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_CMPRD: begin
                // read addresses bi_reg issued, data next cycle
                if (bi_reg == name_len) begin
                    state_next = S_UPDATE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (sn_rdata != nb_rdata) begin
                    idx_next   = idx_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                    state_next = (tries_reg == (SW+1)'(TABLE_SLOTS - 1)) ? S_CHECK : S_PROBE;
                    if (tries_reg == (SW+1)'(TABLE_SLOTS - 1)) begin
                        o_valid_next = 1'b1; o_user_next = 1'b0;
                        o_data_next  = pack_out('0, 1'b0, 1'b0, sta_pkg::ST_FULL,
                                                name_len, '0, info.temp, '0);
                        line_clear = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    bi_next    = bi_reg + 1'b1;
                    state_next = S_CMPRD;
                end
            end
            S_UPDATE: begin
                o_valid_next = 1'b1; o_user_next = 1'b0;
                line_clear   = 1'b1;
                state_next   = S_IDLE;
                if (a_cnt == sta_pkg::COUNT_MAX) begin
                    o_data_next = pack_out(10'(idx_reg), 1'b1, 1'b0, sta_pkg::ST_SATURATED,
                                           name_len, '0, info.temp, agg_rdata);
                end else begin
                    agg_we      = 1'b1;
                    agg_wdata   = {n_min, n_max, a_sum + 43'(info.temp), a_cnt + 32'd1};
                    o_data_next = pack_out(10'(idx_reg), 1'b1, 1'b0, sta_pkg::ST_OK,
                                           name_len, '0, info.temp, agg_wdata);
                end
            end
            S_COPY: begin
                // name buffer read data arrives in the cycle after its copy address
                if (bi_reg != '0) begin
                    sn_we    = 1'b1;
                    sn_waddr = slot_base + BW'(bi_reg - 1'b1);
                end
                if (bi_reg == name_len) begin
                    o_valid_next = 1'b1; o_user_next = 1'b0;
                    o_data_next  = pack_out(10'(idx_reg), 1'b1, 1'b1, sta_pkg::ST_OK,
                                            name_len, '0, info.temp,
                                            {info.temp, info.temp, 43'(info.temp), 32'd1});
                    line_clear = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            S_RDWAIT: begin
                sn_raddr   = slot_base + BW'(rd_bi_reg[NW-1:0]);
                state_next = S_RDOUT;
            end
            S_RDOUT: begin
                o_valid_next = 1'b1; o_user_next = 1'b1;
                if (dir_rdata[DW-1]) begin
                    o_data_next = pack_out(10'(idx_reg), 1'b1, 1'b0, sta_pkg::ST_OK,
                                           dir_rdata[DW-2 -: LW],
                                           (rd_bi_reg < dir_rdata[DW-2 -: LW]) ? sn_rdata : 8'd0,
                                           '0, agg_rdata);
                end else begin
                    o_data_next = pack_out(10'(idx_reg), 1'b0, 1'b0, sta_pkg::ST_OK,
                                           '0, '0, '0, '0);
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            o_valid_reg <= 1'b0;
            tries_reg   <= '0;
            bi_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            o_valid_reg <= o_valid_next;
            tries_reg   <= tries_next;
            bi_reg      <= bi_next;
        end
        h_reg      <= h_next;
        idx_reg    <= idx_next;
        rd_bi_reg  <= rd_bi_next;
        o_data_reg <= o_data_next;
        o_user_reg <= o_user_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

endmodule

// ===== hdl/sta_checker.sv =====
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks of the station temperature aggregator.
// ----------------------------------------------------------------------------
module sta_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         m_tuser
);

    // no word taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");

    // status code stays in range
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:12] <= 3'd4) else $error("bad status");

    // a readout never reports an insert
    a_rd_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[11]) else $error("readout marked inserted");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind station_temperature_aggregator sta_checker u_sta_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
